### sv/pit_pkg.sv
// Package with shared constants for the point-in-tetrahedron test
`timescale 1ns / 1ps
`default_nettype none
package pit_pkg;
	localparam int TOL_WIDTH = 16;
	localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd66;
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;
	localparam logic [0:0] REG_TOLERANCE = 1'b0;
endpackage
`default_nettype wire

### sv/pit_if.sv
// Valid/ready channel interfaces for query items and results
`timescale 1ns / 1ps
`default_nettype none
interface pit_in_if #(parameter int CW = 16);
	logic valid;
	logic ready;
	logic action;
	logic [1:0] vertex_index;
	logic signed [CW-1:0] coord_x;
	logic signed [CW-1:0] coord_y;
	logic signed [CW-1:0] coord_z;
	modport source (output valid, action, vertex_index, coord_x, coord_y, coord_z,
		input ready);
	modport sink (input valid, action, vertex_index, coord_x, coord_y, coord_z,
		output ready);
endinterface

interface pit_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic degenerate;
	modport source (output valid, inside_res, degenerate, input ready);
	modport sink (input valid, inside_res, degenerate, output ready);
endinterface
`default_nettype wire

### sv/pit_det.sv
// Pipelined 3x3 determinant of coordinate differences (four register stages)
`timescale 1ns / 1ps
`default_nettype none
module pit_det #(
	parameter int CW = 16
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic signed [CW-1:0] p0 [3],
	input  wire logic signed [CW-1:0] p1 [3],
	input  wire logic signed [CW-1:0] p2 [3],
	input  wire logic signed [CW-1:0] p3 [3],
	output logic [3*CW+4:0] vol
);
	localparam int DW = CW + 1;
	localparam int MW = 2 * DW + 1;
	localparam int RW = 3 * DW + 3;
	localparam int VW = 3 * CW + 5;
	logic signed [DW-1:0] a_s1 [3];
	logic signed [DW-1:0] b_s1 [3];
	logic signed [DW-1:0] c_s1 [3];
	logic signed [MW-1:0] t_s2 [3];
	logic signed [DW-1:0] a_s2 [3];
	logic signed [RW-1:0] m_s3 [3];
	logic signed [RW-1:0] r;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= DW'(p1[i]) - DW'(p0[i]);
				b_s1[i] <= DW'(p2[i]) - DW'(p0[i]);
				c_s1[i] <= DW'(p3[i]) - DW'(p0[i]);
			end
			t_s2[0] <= MW'(b_s1[1] * c_s1[2]) - MW'(b_s1[2] * c_s1[1]);
			t_s2[1] <= MW'(b_s1[0] * c_s1[2]) - MW'(b_s1[2] * c_s1[0]);
			t_s2[2] <= MW'(b_s1[0] * c_s1[1]) - MW'(b_s1[1] * c_s1[0]);
			a_s2 <= a_s1;
			for (int i = 0; i < 3; i++)
				m_s3[i] <= RW'(t_s2[i]) * RW'(a_s2[i]);
			vol <= r[RW-1] ? VW'(-r) : VW'(r);
		end
	end

	assign r = m_s3[0] - m_s3[1] + m_s3[2];
endmodule
`default_nettype wire

### sv/pit_cmp.sv
// Volume sum and tolerance compare stages
`timescale 1ns / 1ps
`default_nettype none
module pit_cmp #(
	parameter int CW = 16,
	parameter int TFB = 16
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [3*CW+4:0] vol [5],
	input  wire logic [15:0] tol,
	output logic hit,
	output logic degen
);
	localparam int VW = 3 * CW + 5;
	localparam int SW = VW + 2;
	localparam int LW = SW + TFB + 1;
	logic [VW-1:0] tot_s5;
	logic [SW-1:0] sum_s5;
	logic [SW-1:0] diff_s6;
	logic [VW-1:0] tot_s6;
	logic [15:0] tol_s6;
	logic [LW-1:0] lhs_s7;
	logic [LW-1:0] rhs_s7;
	logic degen_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			tot_s5 <= vol[0];
			sum_s5 <= SW'(vol[1]) + SW'(vol[2]) + SW'(vol[3]) + SW'(vol[4]);
			diff_s6 <= (SW'(tot_s5) >= sum_s5) ? SW'(tot_s5) - sum_s5
				: sum_s5 - SW'(tot_s5);
			tot_s6 <= tot_s5;
			tol_s6 <= tol;
			lhs_s7 <= LW'(diff_s6) << TFB;
			rhs_s7 <= LW'(tot_s6) * LW'(tol_s6);
			degen_s7 <= (tot_s6 == '0);
		end
	end

	assign hit = !degen_s7 && (lhs_s7 < rhs_s7);
	assign degen = degen_s7;
endmodule
`default_nettype wire

### sv/point_in_tetrahedron_test.sv
// Point-in-tetrahedron volume test, top level
// One item per cycle is accepted while the output is not stalled.
// Five determinant pipelines run in parallel, then sum, difference and multiply
// stages; the final compare is on the output.
// The pipeline advances whenever its last stage is empty or its result is taken.
// Loads give no result. Reset (arst_n low) clears vertices to zero, tolerance
// to 66, and all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module point_in_tetrahedron_test import pit_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int TOL_FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pit_in_if.sink   in_ch,
	pit_out_if.source out_ch,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CW = COORD_WIDTH;
	localparam int DEPTH = 7;
	logic [TOL_WIDTH-1:0] tol_q;
	logic signed [CW-1:0] vtx_q [4][3];
	logic signed [CW-1:0] pt [3];
	logic signed [CW-1:0] sel [4][4][3];
	logic [3*CW+4:0] vol [5];
	logic [DEPTH-1:0] vld_q;
	logic en, take, wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_TOLERANCE) ? 32'(tol_q) : 32'd0;

	assign take = in_ch.valid && in_ch.ready;
	assign en = !vld_q[DEPTH-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			vld_q <= '0;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 3; j++)
					vtx_q[i][j] <= '0;
		end else begin
			if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_TOLERANCE)
				tol_q <= pwdata[TOL_WIDTH-1:0];
			if (en)
				vld_q <= {vld_q[DEPTH-2:0], take && in_ch.action == ACT_QUERY};
			if (take && in_ch.action == ACT_LOAD) begin
				vtx_q[in_ch.vertex_index][0] <= in_ch.coord_x;
				vtx_q[in_ch.vertex_index][1] <= in_ch.coord_y;
				vtx_q[in_ch.vertex_index][2] <= in_ch.coord_z;
			end
		end
	end

	assign pt[0] = in_ch.coord_x;
	assign pt[1] = in_ch.coord_y;
	assign pt[2] = in_ch.coord_z;

	// sel[k]: stored vertices with vertex k replaced by the query point
	always_comb begin
		for (int k = 0; k < 4; k++)
			for (int j = 0; j < 4; j++)
				for (int c = 0; c < 3; c++)
					sel[k][j][c] = (j == k) ? pt[c] : vtx_q[j][c];
	end

	pit_det #(.CW(CW)) u_tot (.clk(clk), .en(en), .p0(vtx_q[0]), .p1(vtx_q[1]),
		.p2(vtx_q[2]), .p3(vtx_q[3]), .vol(vol[0]));
	for (genvar k = 0; k < 4; k++) begin : g_sub
		pit_det #(.CW(CW)) u_sub (.clk(clk), .en(en), .p0(sel[k][0]), .p1(sel[k][1]),
			.p2(sel[k][2]), .p3(sel[k][3]), .vol(vol[k+1]));
	end

	pit_cmp #(.CW(CW), .TFB(TOL_FRAC_BITS)) u_cmp (.clk(clk), .en(en), .vol(vol),
		.tol(tol_q), .hit(out_ch.inside_res), .degen(out_ch.degenerate));

	assign out_ch.valid = vld_q[DEPTH-1];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.inside_res))
		else $error("result changed during stall");
	a_degen_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.degenerate |-> !out_ch.inside_res)
		else $error("degenerate result reported inside");
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !in_ch.ready)
		else $error("input accepted while pipeline stalled");
endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the point-in-tetrahedron volume test
`timescale 1ns / 1ps
module tb_top;
	import pit_pkg::*;

	localparam int CW = 16;
	localparam int FRAC = 16;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef logic signed [159:0] wide_t;
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;
	typedef struct packed {
		logic action;
		logic [1:0] vertex_index;
		logic signed [CW-1:0] coord_x;
		logic signed [CW-1:0] coord_y;
		logic signed [CW-1:0] coord_z;
	} item_t;
	typedef struct packed {
		logic inside_res;
		logic degenerate;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pit_in_if #(.CW(CW)) in_ch ();
	pit_out_if out_ch ();

	point_in_tetrahedron_test #(.COORD_WIDTH(CW), .TOL_FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	item_t pending_items[$];
	verdict_t expected_verdicts[$];
	point_t vertices[4];
	logic [TOL_WIDTH-1:0] tol_model;
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off_req = 0;
	bit hold_off_done = 0;

	// six times the signed volume of p0 p1 p2 p3
	function automatic wide_t tetra_volume6(point_t p0, point_t p1, point_t p2, point_t p3);
		wide_t ax, ay, az, bx, by, bz, cx, cy, cz, t0, t1, t2;
		ax = p1.x - p0.x; ay = p1.y - p0.y; az = p1.z - p0.z;
		bx = p2.x - p0.x; by = p2.y - p0.y; bz = p2.z - p0.z;
		cx = p3.x - p0.x; cy = p3.y - p0.y; cz = p3.z - p0.z;
		t0 = by * cz - bz * cy;
		t1 = bx * cz - bz * cx;
		t2 = bx * cy - by * cx;
		return t0 * ax - t1 * ay + t2 * az;
	endfunction

	function automatic wide_t wabs(wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic verdict_t classify_point(point_t p);
		verdict_t v;
		wide_t total, sum, diff, tolw;
		point_t q[4];
		total = wabs(tetra_volume6(vertices[0], vertices[1], vertices[2], vertices[3]));
		v.inside_res = 1'b0;
		v.degenerate = 1'b0;
		if (total == 0) begin
			v.degenerate = 1'b1;
			return v;
		end
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			q = vertices;
			q[i] = p;
			sum = sum + wabs(tetra_volume6(q[0], q[1], q[2], q[3]));
		end
		diff = wabs(total - sum);
		tolw = {144'b0, tol_model};
		v.inside_res = ((diff <<< FRAC) < total * tolw);
		return v;
	endfunction

	task automatic apply_item(item_t it);
		point_t p;
		p.x = it.coord_x;
		p.y = it.coord_y;
		p.z = it.coord_z;
		if (it.action == ACT_LOAD)
			vertices[it.vertex_index] = p;
		else
			expected_verdicts.push_back(classify_point(p));
	endtask

	// input driver
	int in_gap = 0;
	bit in_calm = 0;
	always @(posedge clk) begin
		item_t it;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				it = {in_ch.action, in_ch.vertex_index, in_ch.coord_x,
					in_ch.coord_y, in_ch.coord_z};
				apply_item(it);
				if ($urandom_range(0, 39) == 0)
					in_calm = !in_calm;
				in_gap = in_calm ? 0 : $urandom_range(0, 5);
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					it = pending_items.pop_front();
					in_ch.action <= it.action;
					in_ch.vertex_index <= it.vertex_index;
					in_ch.coord_x <= it.coord_x;
					in_ch.coord_y <= it.coord_y;
					in_ch.coord_z <= it.coord_z;
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	int out_wait = 0;
	int out_hold = 0;
	bit out_calm = 0;
	always @(posedge clk) begin
		verdict_t exp_v;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result transaction with no expectation pending");
					errors++;
				end else begin
					exp_v = expected_verdicts.pop_front();
					if (out_ch.inside_res !== exp_v.inside_res) begin
						$error("inside_res: expected %0d, actual %0d",
							exp_v.inside_res, out_ch.inside_res);
						errors++;
					end
					if (out_ch.degenerate !== exp_v.degenerate) begin
						$error("degenerate: expected %0d, actual %0d",
							exp_v.degenerate, out_ch.degenerate);
						errors++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					out_calm = !out_calm;
				out_wait = out_calm ? 0 : $urandom_range(0, 5);
			end
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1;
				out_hold = HOLD_OFF_CYCLES;
			end
			if (out_hold > 0) begin
				out_hold--;
				out_ch.ready <= 1'b0;
			end else if (out_wait > 0) begin
				out_wait--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[point_in_tetrahedron_test] ERROR");
				$finish;
			end
		end
	end

	task automatic write_tolerance(logic [TOL_WIDTH-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(REG_TOLERANCE) << 2;
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tol_model = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic add_item(logic action, logic [1:0] idx, int x, int y, int z);
		item_t it;
		it.action = action;
		it.vertex_index = idx;
		it.coord_x = x[CW-1:0];
		it.coord_y = y[CW-1:0];
		it.coord_z = z[CW-1:0];
		pending_items.push_back(it);
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 4))
			0: return $signed(16'($urandom));
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			2: return int'($urandom_range(0, 64)) - 32;
			default: return int'($urandom_range(0, 8000)) - 4000;
		endcase
	endfunction

	// load a tetrahedron, then query points around it, at its vertices and at random
	task automatic add_tetra_set(int n_queries);
		int vx[4], vy[4], vz[4];
		int cx, cy, cz, spread;
		for (int i = 0; i < 4; i++) begin
			vx[i] = rand_coord();
			vy[i] = rand_coord();
			vz[i] = rand_coord();
		end
		if ($urandom_range(0, 9) == 0) begin
			vx[3] = vx[2]; vy[3] = vy[2]; vz[3] = vz[2];
		end
		for (int i = 0; i < 4; i++)
			add_item(ACT_LOAD, 2'(i), vx[i], vy[i], vz[i]);
		cx = (vx[0] + vx[1] + vx[2] + vx[3]) / 4;
		cy = (vy[0] + vy[1] + vy[2] + vy[3]) / 4;
		cz = (vz[0] + vz[1] + vz[2] + vz[3]) / 4;
		for (int q = 0; q < n_queries; q++) begin
			case ($urandom_range(0, 5))
				0: add_item(ACT_QUERY, 2'($urandom), rand_coord(), rand_coord(),
					rand_coord());
				1: begin
					// a stored vertex, on the boundary
					int k = $urandom_range(0, 3);
					add_item(ACT_QUERY, 2'($urandom), vx[k], vy[k], vz[k]);
				end
				default: begin
					spread = 1 << $urandom_range(0, 13);
					add_item(ACT_QUERY, 2'($urandom),
						cx + int'($urandom_range(0, 2 * spread)) - spread,
						cy + int'($urandom_range(0, 2 * spread)) - spread,
						cz + int'($urandom_range(0, 2 * spread)) - spread);
				end
			endcase
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() > 0 || in_ch.valid || expected_verdicts.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_random_phase(int n_items);
		int start = pending_items.size();
		while (pending_items.size() - start < n_items) begin
			if ($urandom_range(0, 7) == 0)
				add_item(logic'($urandom), 2'($urandom), rand_coord(), rand_coord(),
					rand_coord());
			else
				add_tetra_set($urandom_range(1, 12));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = ACT_LOAD;
		in_ch.vertex_index = '0;
		in_ch.coord_x = '0;
		in_ch.coord_y = '0;
		in_ch.coord_z = '0;
		out_ch.ready = 1'b0;
		tol_model = TOL_RESET;
		foreach (vertices[i])
			vertices[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: degenerate after reset, unit corner, extremes
		add_item(ACT_QUERY, 2'd0, 0, 0, 0);
		add_item(ACT_LOAD, 2'd0, 0, 0, 0);
		add_item(ACT_LOAD, 2'd1, 1000, 0, 0);
		add_item(ACT_LOAD, 2'd2, 0, 1000, 0);
		add_item(ACT_LOAD, 2'd3, 0, 0, 1000);
		add_item(ACT_QUERY, 2'd3, 250, 250, 250);
		add_item(ACT_QUERY, 2'd1, 1000, 0, 0);
		add_item(ACT_QUERY, 2'd2, -1, 0, 0);
		add_item(ACT_QUERY, 2'd0, 32767, 32767, 32767);
		add_item(ACT_QUERY, 2'd0, -32768, -32768, -32768);
		add_item(ACT_LOAD, 2'd0, -32768, -32768, -32768);
		add_item(ACT_LOAD, 2'd1, 32767, -32768, -32768);
		add_item(ACT_LOAD, 2'd2, -32768, 32767, -32768);
		add_item(ACT_LOAD, 2'd3, -32768, -32768, 32767);
		add_item(ACT_QUERY, 2'd0, 0, 0, 0);
		add_item(ACT_QUERY, 2'd0, -16384, -16384, -16384);
		add_item(ACT_QUERY, 2'd3, 32767, 32767, 32767);
		add_item(ACT_LOAD, 2'd3, 32767, -32768, -32768);
		add_item(ACT_QUERY, 2'd1, 5, 5, 5);
		wait_idle();

		write_tolerance(16'd0);
		add_tetra_set(10);
		wait_idle();

		write_tolerance(16'hFFFF);
		add_random_phase(300);
		wait_idle();

		write_tolerance(TOL_RESET);
		@(posedge clk);
		hold_off_req <= 1'b1;
		add_random_phase(300);
		wait_idle();

		write_tolerance(16'd0);
		add_random_phase(150);
		wait_idle();

		write_tolerance(16'($urandom_range(1, 4096)));
		add_random_phase(300);
		wait_idle();

		write_tolerance(16'($urandom));
		add_random_phase(150);
		wait_idle();

		if (expected_verdicts.size() > 0) begin
			$error("%0d expected results never arrived", expected_verdicts.size());
			errors++;
		end
		if (errors == 0)
			$display("[point_in_tetrahedron_test] OK");
		else
			$display("[point_in_tetrahedron_test] ERROR");
		$finish;
	end
endmodule

### files.f
sv/pit_pkg.sv
sv/pit_if.sv
sv/pit_det.sv
sv/pit_cmp.sv
sv/point_in_tetrahedron_test.sv
dv/tb_top.sv
